>>> hdl/csma_pkg.sv
// Package for the clamped scale moving average block.
// Holds the field widths, register indexes, reset values, divider bundles and the
// sequencer state type. It depends on nothing else.
`timescale 1ns / 1ps

package csma_pkg;

   localparam int DATA_W             = 12;
   localparam int DEFAULT_WINDOW_LEN = 20;
   localparam int CSR_IDX_W          = 2;
   localparam int DVD_W              = 2 * DATA_W;
   localparam int REQ_TDATA_W        = 16;
   localparam int RSP_TDATA_W        = 2 * DATA_W;

   localparam logic [CSR_IDX_W-1:0] REG_VOLT_LOW   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_VOLT_HIGH  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_FULL_SCALE = 2'd2;

   localparam logic [DATA_W-1:0] VOLT_LOW_RST   = 12'd0;
   localparam logic [DATA_W-1:0] VOLT_HIGH_RST  = 12'd3300;
   localparam logic [DATA_W-1:0] FULL_SCALE_RST = 12'd1500;

   typedef struct packed {
      logic              start;
      logic [DVD_W-1:0]  dividend;
      logic [DATA_W-1:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic              done;
      logic [DATA_W-1:0] quotient;
   } div_rsp_type;

   typedef enum logic [6:0] {
      ST_IDLE  = 7'b0000001,
      ST_MUL   = 7'b0000010,
      ST_SCALE = 7'b0000100,
      ST_DIV1  = 7'b0001000,
      ST_SUM   = 7'b0010000,
      ST_MEAN  = 7'b0100000,
      ST_PUSH  = 7'b1000000
   } fsm_type;

endpackage

>>> hdl/csma_div.sv
// Iterative restoring divider, one quotient bit per cycle.
// Depends on csma_pkg for widths and the request and response bundles.
`timescale 1ns / 1ps

module csma_div (
   input  logic                 clock,
   input  logic                 reset,
   input  csma_pkg::div_req_type req,
   output csma_pkg::div_rsp_type rsp
);
   import csma_pkg::*;

   localparam int CNT_W = $clog2(DATA_W);

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [DATA_W-1:0] rem_ff, rem_in;
   logic [DATA_W-1:0] low_ff, low_in;
   logic [DATA_W-1:0] quo_ff, quo_in;
   logic [DATA_W:0]   trial;
   logic              fits;

   // The caller guarantees that the quotient fits in DATA_W bits, so the upper
   // half of the dividend is already below the divisor.
   assign trial = {rem_ff, low_ff[DATA_W-1]};
   assign fits  = trial >= {1'b0, req.divisor};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      low_in  = low_ff;
      quo_in  = quo_ff;
      if (req.start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = req.dividend[DVD_W-1:DATA_W];
         low_in  = req.dividend[DATA_W-1:0];
      end else if (busy_ff) begin
         rem_in = fits ? DATA_W'(trial - {1'b0, req.divisor}) : trial[DATA_W-1:0];
         low_in = {low_ff[DATA_W-2:0], 1'b0};
         quo_in = {quo_ff[DATA_W-2:0], fits};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CNT_W'(DATA_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      low_ff <= low_in;
      quo_ff <= quo_in;
   end

   assign rsp.done     = done_ff;
   assign rsp.quotient = quo_ff;

endmodule

>>> hdl/csma_window.sv
// Window store: a synchronous memory of speeds with a registered read port.
// Entries not yet written since reset read as zero. Depends on csma_pkg.
`timescale 1ns / 1ps

module csma_window #(
   parameter int WINDOW_LEN = csma_pkg::DEFAULT_WINDOW_LEN
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          rd_en,
   input  logic [$clog2(WINDOW_LEN)-1:0] rd_addr,
   output logic [csma_pkg::DATA_W-1:0]   rd_data,
   input  logic                          wr_en,
   input  logic [$clog2(WINDOW_LEN)-1:0] wr_addr,
   input  logic [csma_pkg::DATA_W-1:0]   wr_data
);
   import csma_pkg::*;

   logic [DATA_W-1:0]     mem_ff [WINDOW_LEN];
   logic [WINDOW_LEN-1:0] valid_ff;
   logic [DATA_W-1:0]     rd_data_ff;
   logic                  rd_valid_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         if (wr_en) begin
            valid_ff[wr_addr] <= 1'b1;
         end
         if (rd_en) begin
            rd_valid_ff <= valid_ff[rd_addr];
         end
      end
   end

   assign rd_data = rd_valid_ff ? rd_data_ff : '0;

endmodule

>>> hdl/clamped_scale_moving_average.sv
// Top level of the clamped scale moving average block.
// Depends on csma_pkg, csma_div and csma_window.
`timescale 1ns / 1ps
//
// Each beat on the req_ channel carries one sensor voltage in millivolts. The block
// clamps it linearly to a speed in tenths of km/h (zero at or below volt_low, the
// full scale value at or above volt_high, otherwise a truncated linear scale), writes
// that speed over the oldest entry of a window of WINDOW_LEN speeds, updates a running
// sum and returns one beat on the rsp_ channel with the current speed and the
// truncated window mean.
// An accepted request beat passes through the states MUL, SCALE, DIV1, SUM, MEAN and
// PUSH, skipping DIV1 when the voltage is clamped. The scaling uses the one-bit-per-cycle
// divider; the window mean is a product with the reciprocal of WINDOW_LEN, registered in
// MEAN. One item is worked on at a time, so a new request beat is taken only once the
// sequencer is back in IDLE.
// A finished response sits in an output register, so the next request is accepted
// while the receiver stalls; a second response then waits in the sequencer until the
// output register is free. The csr_ port writes the three registers; use it only
// while the block is idle, which the block itself does not enforce.
// A synchronous reset restores the register defaults, clears the window (through
// per-entry valid bits, so no clearing pass is needed), the sum and the write
// position, and drops any response not yet taken.

module clamped_scale_moving_average #(
   parameter int WINDOW_LEN = csma_pkg::DEFAULT_WINDOW_LEN
) (
   input  logic                              clock,
   input  logic                              reset,
   // Request: sample_mv in [11:0], zero above.
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [csma_pkg::REQ_TDATA_W-1:0]  req_tdata,
   // Response: speed_now in [11:0], speed_average in [23:12].
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [csma_pkg::RSP_TDATA_W-1:0]  rsp_tdata,
   // Register writes.
   input  logic                              csr_wen,
   input  logic [csma_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [csma_pkg::DATA_W-1:0]       csr_wdata
);
   import csma_pkg::*;

   localparam int IDX_W = $clog2(WINDOW_LEN);
   localparam int SUM_W = $clog2(WINDOW_LEN * ((1 << DATA_W) - 1) + 1);

   // The mean is sum * RECIP_M >> RECIP_SH. With the shift this long the rounded-up
   // reciprocal gives the exact truncated quotient for every sum that can occur.
   localparam int RECIP_SH = SUM_W + $clog2(WINDOW_LEN);
   localparam int RECIP_W  = SUM_W + 1;
   localparam int MPROD_W  = SUM_W + RECIP_W;
   localparam logic [RECIP_W-1:0] RECIP_M =
      RECIP_W'(((64'd1 << RECIP_SH) + 64'(WINDOW_LEN) - 64'd1) / 64'(WINDOW_LEN));

   fsm_type           state_ff, state_in;

   logic [DATA_W-1:0] volt_low_ff, volt_high_ff, full_scale_ff;

   logic [DATA_W-1:0] mv_ff;
   logic [DVD_W-1:0]  prod_ff;
   logic [DATA_W-1:0] span_ff;
   logic              is_zero_ff, is_full_ff;
   logic [DATA_W-1:0] speed_ff, speed_in;
   logic [DATA_W-1:0] avg_ff, avg_in;
   logic [SUM_W-1:0]  sum_ff, sum_in;
   logic [IDX_W-1:0]  pos_ff, pos_in;

   logic                   rsp_tvalid_ff, rsp_tvalid_in;
   logic [RSP_TDATA_W-1:0] rsp_tdata_ff, rsp_tdata_in;

   logic               accept;
   logic               out_free;
   logic [DATA_W-1:0]  old_speed;
   logic [MPROD_W-1:0] mean_prod;
   div_req_type        div_req;
   div_rsp_type        div_rsp;

   assign req_tready = (state_ff == ST_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign out_free   = !rsp_tvalid_ff || rsp_tready;

   // Configuration registers. Writes to an index beyond the list fall through.
   always_ff @(posedge clock) begin
      if (reset) begin
         volt_low_ff   <= VOLT_LOW_RST;
         volt_high_ff  <= VOLT_HIGH_RST;
         full_scale_ff <= FULL_SCALE_RST;
      end else if (csr_wen) begin
         case (csr_index)
            REG_VOLT_LOW:   volt_low_ff   <= csr_wdata;
            REG_VOLT_HIGH:  volt_high_ff  <= csr_wdata;
            REG_FULL_SCALE: full_scale_ff <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   // The old entry is read at acceptance; it is ready well before the sum update.
   csma_window #(
      .WINDOW_LEN (WINDOW_LEN)
   ) u_window (
      .clock   (clock),
      .reset   (reset),
      .rd_en   (accept),
      .rd_addr (pos_ff),
      .rd_data (old_speed),
      .wr_en   (state_ff == ST_SUM),
      .wr_addr (pos_ff),
      .wr_data (speed_ff)
   );

   // The divider serves the scaling only. Its quotient fits in DATA_W bits because the
   // scaled speed stays below full scale.
   always_comb begin
      div_req.start    = (state_ff == ST_SCALE) && !is_zero_ff && !is_full_ff;
      div_req.dividend = prod_ff;
      div_req.divisor  = span_ff;
   end

   csma_div u_div (
      .clock (clock),
      .reset (reset),
      .req   (div_req),
      .rsp   (div_rsp)
   );

   assign sum_in = (state_ff == ST_SUM) ?
                   SUM_W'(sum_ff - SUM_W'(old_speed) + SUM_W'(speed_ff)) : sum_ff;

   // Window mean from the updated sum, read in the cycle after SUM.
   assign mean_prod = MPROD_W'(sum_ff) * MPROD_W'(RECIP_M);

   always_comb begin
      state_in      = state_ff;
      speed_in      = speed_ff;
      avg_in        = avg_ff;
      pos_in        = pos_ff;
      rsp_tvalid_in = rsp_tvalid_ff && !rsp_tready;
      rsp_tdata_in  = rsp_tdata_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            state_in = ST_SCALE;
         end
         ST_SCALE: begin
            // The low test comes first, so an empty or inverted span gives full scale
            // for anything above volt_low.
            if (is_zero_ff) begin
               speed_in = '0;
               state_in = ST_SUM;
            end else if (is_full_ff) begin
               speed_in = full_scale_ff;
               state_in = ST_SUM;
            end else begin
               state_in = ST_DIV1;
            end
         end
         ST_DIV1: begin
            if (div_rsp.done) begin
               speed_in = div_rsp.quotient;
               state_in = ST_SUM;
            end
         end
         ST_SUM: begin
            pos_in   = (pos_ff == IDX_W'(WINDOW_LEN - 1)) ? '0 : IDX_W'(pos_ff + 1'b1);
            state_in = ST_MEAN;
         end
         ST_MEAN: begin
            avg_in   = DATA_W'(mean_prod >> RECIP_SH);
            state_in = ST_PUSH;
         end
         ST_PUSH: begin
            if (out_free) begin
               rsp_tvalid_in = 1'b1;
               rsp_tdata_in  = {avg_ff, speed_ff};
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         sum_ff        <= '0;
         pos_ff        <= '0;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         sum_ff        <= sum_in;
         pos_ff        <= pos_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
      speed_ff     <= speed_in;
      avg_ff       <= avg_in;
      rsp_tdata_ff <= rsp_tdata_in;
   end

   // Sample capture, then the clamp tests and the product in the following cycle.
   always_ff @(posedge clock) begin
      if (accept) begin
         mv_ff <= req_tdata[DATA_W-1:0];
      end
      if (state_ff == ST_MUL) begin
         is_zero_ff <= mv_ff <= volt_low_ff;
         is_full_ff <= mv_ff >= volt_high_ff;
         prod_ff    <= DVD_W'(DATA_W'(mv_ff - volt_low_ff)) * DVD_W'(full_scale_ff);
         span_ff    <= DATA_W'(volt_high_ff - volt_low_ff);
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;

endmodule

>>> bench/tb_clamped_scale_moving_average.sv
// Self-checking testbench for clamped_scale_moving_average.
// Drives sample beats, register writes and response back-pressure, and checks every response
// against its own speed scaler and window predictor. Depends on csma_pkg and the block's RTL.
`timescale 1ns / 1ps

module tb_clamped_scale_moving_average;

   import csma_pkg::*;

   // The block is built with its default window; the predictor keeps the same length.
   localparam int WIN_LEN = DEFAULT_WINDOW_LEN;

   // Index 3 is decoded by nobody, so a write there must leave every register alone.
   localparam logic [CSR_IDX_W-1:0] REG_SPARE = 2'd3;

   // Generous ceiling on the run length in clock cycles; the slowest correct run is far below.
   localparam int CYCLE_LIMIT = 400000;

   // Long receiver hold-off, in cycles, used once to make the block stall its input.
   localparam int HOLD_OFF_CYCLES = 300;

   typedef struct packed {
      logic [DATA_W-1:0] speed_now;
      logic [DATA_W-1:0] speed_average;
   } speed_pair_type;

   typedef struct {
      logic [DATA_W-1:0] sample_mv;
      bit                typed;
      logic [DATA_W-1:0] speed_now;
      logic [DATA_W-1:0] speed_average;
   } sample_row_type;

   typedef struct {
      logic [DATA_W-1:0] volt_low;
      logic [DATA_W-1:0] volt_high;
      logic [DATA_W-1:0] full_scale;
   } reg_setting_type;

   logic                   clock;
   logic                   reset;
   logic                   req_tvalid;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata;   // sample_mv [11:0], zero above
   logic                   rsp_tvalid;
   logic                   rsp_tready;
   logic [RSP_TDATA_W-1:0] rsp_tdata;   // speed_now [11:0], speed_average [23:12]
   logic                   csr_wen;
   logic [CSR_IDX_W-1:0]   csr_index;
   logic [DATA_W-1:0]      csr_wdata;

   // Predictor copy of the registers and of the speed window.
   logic [DATA_W-1:0] volt_low_m;
   logic [DATA_W-1:0] volt_high_m;
   logic [DATA_W-1:0] full_scale_m;
   logic [DATA_W-1:0] speed_window_m [WIN_LEN];
   int unsigned       window_pos_m;
   logic [16:0]       window_sum_m;

   // Responses that the block still owes, oldest first.
   speed_pair_type pending_speeds [$];

   int unsigned beats_sent;
   int unsigned beats_checked;
   int unsigned mismatch_count;
   int unsigned settings_used;
   int unsigned cycle_count;
   bit          no_idle_tail;
   bit          hold_off_done;

   clamped_scale_moving_average u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_wen    (csr_wen),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   // Clamped linear scaling followed by the running window update. The scaling tests run in
   // the same order as in the block: the low clamp first, so an inverted or empty voltage span
   // gives full scale for anything above volt_low and never reaches the division.
   function automatic speed_pair_type scale_and_average(input logic [DATA_W-1:0] mv);
      logic [31:0]       product;
      logic [DATA_W-1:0] speed;
      speed_pair_type    result;
      if (mv <= volt_low_m) begin
         speed = '0;
      end else if (mv >= volt_high_m) begin
         speed = full_scale_m;
      end else begin
         product = (32'(mv) - 32'(volt_low_m)) * 32'(full_scale_m);
         speed   = DATA_W'(product / (32'(volt_high_m) - 32'(volt_low_m)));
      end
      window_sum_m = window_sum_m - 17'(speed_window_m[window_pos_m]) + 17'(speed);
      speed_window_m[window_pos_m] = speed;
      window_pos_m = (window_pos_m + 1 >= WIN_LEN) ? 0 : window_pos_m + 1;
      result.speed_now     = speed;
      result.speed_average = DATA_W'(window_sum_m / WIN_LEN);
      return result;
   endfunction

   // Most samples fall inside the live voltage span so that the divider does real work; the
   // rest sit on or next to the clamp points, at either end of the 12-bit range, or anywhere in it.
   function automatic logic [DATA_W-1:0] pick_sample();
      int lo;
      int hi;
      int v;
      lo = int'(volt_low_m);
      hi = int'(volt_high_m);
      case ($urandom_range(0, 9))
         0: v = int'($urandom_range(0, 4095));
         1: v = lo + int'($urandom_range(0, 4)) - 2;
         2: v = hi + int'($urandom_range(0, 4)) - 2;
         3: v = $urandom_range(0, 1) ? 4095 : 0;
         default: begin
            if (hi > lo) begin
               v = int'($urandom_range(lo, hi));
            end else begin
               v = int'($urandom_range(0, 4095));
            end
         end
      endcase
      if (v < 0) begin
         v = 0;
      end
      if (v > 4095) begin
         v = 4095;
      end
      return DATA_W'(v);
   endfunction

   // Offers one sample beat, optionally after a random idle burst, and waits for the handshake.
   // It is entered and left at a falling edge, so req_tvalid gets one assignment per step.
   task automatic send_sample(input logic [DATA_W-1:0] mv, input bit typed,
                              input speed_pair_type typed_pair);
      speed_pair_type predicted;
      if (!no_idle_tail && $urandom_range(0, 2) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 18)) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {{(REQ_TDATA_W - DATA_W){1'b0}}, mv};
      @(posedge clock);
      while (!req_tready) begin
         @(posedge clock);
      end
      // The predictor always advances; rows with a hand-typed answer queue that instead.
      predicted = scale_and_average(mv);
      pending_speeds.push_back(typed ? typed_pair : predicted);
      beats_sent++;
      @(negedge clock);
   endtask

   // Writes the three registers and a spare index while the block is idle. Entered and left
   // at a falling edge; csr_wen stays high across the back-to-back writes.
   task automatic apply_setting(input reg_setting_type s);
      csr_wen   <= 1'b1;
      csr_index <= REG_VOLT_LOW;
      csr_wdata <= s.volt_low;
      @(negedge clock);
      csr_index <= REG_SPARE;
      csr_wdata <= DATA_W'($urandom_range(0, 4095));
      @(negedge clock);
      csr_index <= REG_VOLT_HIGH;
      csr_wdata <= s.volt_high;
      @(negedge clock);
      csr_index <= REG_FULL_SCALE;
      csr_wdata <= s.full_scale;
      @(negedge clock);
      csr_wen <= 1'b0;
      volt_low_m   = s.volt_low;
      volt_high_m  = s.volt_high;
      full_scale_m = s.full_scale;
      settings_used++;
      @(negedge clock);
   endtask

   // Lowers the request valid and waits until every owed response has been taken, then lets
   // the block settle, so it is idle before the next register write.
   task automatic drain_responses();
      req_tvalid <= 1'b0;
      while (pending_speeds.size() != 0) begin
         @(posedge clock);
      end
      repeat (4) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic run_random(input int count);
      speed_pair_type unused_pair;
      unused_pair = '0;
      repeat (count) begin
         send_sample(pick_sample(), 1'b0, unused_pair);
      end
   endtask

   // Response checker: each accepted response beat is compared with the oldest expectation.
   always @(posedge clock) begin
      speed_pair_type wanted;
      speed_pair_type got;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.speed_now     = rsp_tdata[DATA_W-1:0];
         got.speed_average = rsp_tdata[2*DATA_W-1:DATA_W];
         if (pending_speeds.size() == 0) begin
            $display("%0t: unexpected response beat, speed_now %0d speed_average %0d",
                     $time, got.speed_now, got.speed_average);
            mismatch_count++;
         end else begin
            wanted = pending_speeds.pop_front();
            if (got.speed_now !== wanted.speed_now) begin
               $display("%0t: speed_now mismatch, expected %0d actual %0d",
                        $time, wanted.speed_now, got.speed_now);
               mismatch_count++;
            end
            if (got.speed_average !== wanted.speed_average) begin
               $display("%0t: speed_average mismatch, expected %0d actual %0d",
                        $time, wanted.speed_average, got.speed_average);
               mismatch_count++;
            end
            beats_checked++;
         end
      end
   end

   // Watchdog on the whole run.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("%0t: timeout with %0d responses outstanding", $time, pending_speeds.size());
         $display("tb_clamped_scale_moving_average failed");
         $finish;
      end
   end

   // Receiver: random ready bursts and stall bursts, one long hold-off early in the run so that
   // the output register and the sequencer both fill and req_tready drops, and no stalls at
   // all in the closing phase.
   initial begin
      rsp_tready = 1'b0;
      @(negedge clock);
      while (reset) begin
         @(negedge clock);
      end
      forever begin
         if (!hold_off_done && beats_checked >= 40) begin
            hold_off_done = 1'b1;
            rsp_tready <= 1'b0;
            for (int n = 0; n < HOLD_OFF_CYCLES; n++) begin
               @(negedge clock);
            end
         end else if (!no_idle_tail && $urandom_range(0, 2) == 0) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 18)) @(negedge clock);
         end else begin
            rsp_tready <= 1'b1;
            repeat ($urandom_range(1, 24)) @(negedge clock);
         end
      end
   end

   // Main sequence: reset, a directed table under the reset register values, then random
   // samples under a run of register settings that covers the extremes and the clamp cases.
   initial begin
      sample_row_type  directed_rows [24];
      reg_setting_type fixed_settings [8];
      reg_setting_type random_setting;
      reg_setting_type reset_setting;
      speed_pair_type  typed_pair;

      reset          = 1'b1;
      req_tvalid     = 1'b0;
      req_tdata      = '0;
      csr_wen        = 1'b0;
      csr_index      = REG_VOLT_LOW;
      csr_wdata      = '0;
      beats_sent     = 0;
      beats_checked  = 0;
      mismatch_count = 0;
      settings_used  = 1;
      cycle_count    = 0;
      no_idle_tail   = 1'b0;
      hold_off_done  = 1'b0;

      volt_low_m   = VOLT_LOW_RST;
      volt_high_m  = VOLT_HIGH_RST;
      full_scale_m = FULL_SCALE_RST;
      foreach (speed_window_m[i]) begin
         speed_window_m[i] = '0;
      end
      window_pos_m = 0;
      window_sum_m = '0;

      // Reset values 0 mV, 3300 mV, 1500 and an empty window: the first rows show the average
      // ramping up from zero, the clamp points and a value just inside the span. After that
      // come bit patterns, then full-scale samples that wrap the window.
      directed_rows = '{
         '{12'd0,    1'b1, 12'd0,    12'd0},
         '{12'd4095, 1'b1, 12'd1500, 12'd75},
         '{12'd3300, 1'b1, 12'd1500, 12'd150},
         '{12'd1650, 1'b1, 12'd750,  12'd187},
         '{12'd1,    1'b1, 12'd0,    12'd187},
         '{12'd3299, 1'b1, 12'd1499, 12'd262},
         '{12'd3301, 1'b1, 12'd1500, 12'd337},
         '{12'hAAA,  1'b0, 12'd0,    12'd0},
         '{12'h555,  1'b0, 12'd0,    12'd0},
         '{12'h800,  1'b0, 12'd0,    12'd0},
         '{12'h7FF,  1'b0, 12'd0,    12'd0},
         '{12'hF0F,  1'b0, 12'd0,    12'd0},
         '{12'h0F0,  1'b0, 12'd0,    12'd0},
         '{12'd4095, 1'b0, 12'd0,    12'd0},
         '{12'd4095, 1'b0, 12'd0,    12'd0},
         '{12'd4095, 1'b0, 12'd0,    12'd0},
         '{12'd4095, 1'b0, 12'd0,    12'd0},
         '{12'd4095, 1'b0, 12'd0,    12'd0},
         '{12'd4095, 1'b0, 12'd0,    12'd0},
         '{12'd4095, 1'b0, 12'd0,    12'd0},
         '{12'd4095, 1'b0, 12'd0,    12'd0},
         '{12'd4095, 1'b0, 12'd0,    12'd0},
         '{12'd4095, 1'b0, 12'd0,    12'd0},
         '{12'd4095, 1'b0, 12'd0,    12'd0}
      };

      // Register settings: full range with the largest full scale, both clamp points at the
      // top, an empty span at zero, an inverted span, a span one millivolt in from each end, a
      // one-millivolt span, a zero full scale and an ordinary mid-range span.
      fixed_settings = '{
         '{12'd0,    12'd4095, 12'd4095},
         '{12'd4095, 12'd4095, 12'd4095},
         '{12'd0,    12'd0,    12'd4095},
         '{12'd2000, 12'd1000, 12'hAAA},
         '{12'd1,    12'd4094, 12'd4000},
         '{12'd0,    12'd1,    12'd4095},
         '{12'd100,  12'd4095, 12'd0},
         '{12'd1234, 12'd3000, 12'h555}
      };
      reset_setting = '{VOLT_LOW_RST, VOLT_HIGH_RST, FULL_SCALE_RST};

      repeat (12) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      foreach (directed_rows[r]) begin
         typed_pair.speed_now     = directed_rows[r].speed_now;
         typed_pair.speed_average = directed_rows[r].speed_average;
         send_sample(directed_rows[r].sample_mv, directed_rows[r].typed, typed_pair);
      end

      // Random samples under the reset values; the long receiver hold-off falls in here.
      run_random(60);
      drain_responses();

      foreach (fixed_settings[s]) begin
         apply_setting(fixed_settings[s]);
         run_random(35);
         drain_responses();
      end

      repeat (3) begin
         random_setting.volt_low   = DATA_W'($urandom_range(0, 3000));
         random_setting.volt_high  = DATA_W'($urandom_range(random_setting.volt_low + 1, 4095));
         random_setting.full_scale = DATA_W'($urandom_range(0, 4095));
         apply_setting(random_setting);
         run_random(35);
         drain_responses();
      end

      // Closing phase back at the reset values, with both sides running flat out.
      no_idle_tail = 1'b1;
      apply_setting(reset_setting);
      run_random(40);
      drain_responses();
      repeat (40) @(posedge clock);

      $display("Sent %0d sample beats under %0d register settings; %0d responses compared.",
               beats_sent, settings_used, beats_checked);
      $display("The run included a %0d-cycle receiver hold-off and %0d mismatches were seen.",
               HOLD_OFF_CYCLES, mismatch_count);
      if (mismatch_count == 0 && pending_speeds.size() == 0) begin
         $display("tb_clamped_scale_moving_average passed");
      end else begin
         $display("tb_clamped_scale_moving_average failed");
      end
      $finish;
   end

endmodule

>>> filelist.f
hdl/csma_pkg.sv
hdl/csma_div.sv
hdl/csma_window.sv
hdl/clamped_scale_moving_average.sv
bench/tb_clamped_scale_moving_average.sv
